/* src/nddi_pkg.sv */
// ----------------------------------------------------------------------------
// nddi_pkg
// Shared widths, codes and operand bundles of the divided-difference block.
// ----------------------------------------------------------------------------
package nddi_pkg;

   localparam int MAX_NODES = 32;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = ($clog2(MAX_NODES + 1) > 6) ? $clog2(MAX_NODES + 1) : 6;

   localparam int DATA_W = 32;
   localparam int COEF_W = 46;
   localparam int DVD_W  = 64;
   localparam int DSR_W  = 33;
   localparam int MB_W   = 33;
   localparam int PROD_W = COEF_W + 1 + MB_W;

   localparam logic signed [COEF_W-1:0] C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] C_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [1:0] CSR_NODE_START = 2'd0;
   localparam logic [1:0] CSR_NODE_END   = 2'd1;
   localparam logic [1:0] CSR_NODE_COUNT = 2'd2;

   typedef enum logic [1:0] {
      ST_STORED = 2'd0,
      ST_BUILT  = 2'd1,
      ST_VALUE  = 2'd2,
      ST_ERROR  = 2'd3
   } status_type;

   typedef struct packed {
      logic                    start;
      logic signed [DVD_W-1:0] dividend;
      logic signed [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DVD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                     start;
      logic signed [COEF_W-1:0] a;
      logic signed [MB_W-1:0]   b;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [COEF_W-1:0] product;
   } mul_rsp_type;

endpackage

/* src/nddi_div.sv */
// ----------------------------------------------------------------------------
// nddi_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module nddi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  nddi_pkg::div_req_type req,
   output nddi_pkg::div_rsp_type rsp
);

   localparam int DVD_W = nddi_pkg::DVD_W;
   localparam int DSR_W = nddi_pkg::DSR_W;
   localparam int CW    = $clog2(DVD_W);

   logic             run_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DSR_W-1:0] dsr_ff;
   logic [DSR_W-1:0] rem_ff;
   logic             neg_ff;

   logic [DSR_W:0]   rem_sh;
   logic [DSR_W+1:0] diff;
   logic             qbit;
   logic [DSR_W-1:0] rem_in;

   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign qbit   = ~diff[DSR_W+1];
   assign rem_in = qbit ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(DVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         dvd_ff <= req.dividend[DVD_W-1] ? (~req.dividend + DVD_W'(1)) : req.dividend;
         dsr_ff <= req.divisor[DSR_W-1] ? (~req.divisor + DSR_W'(1)) : req.divisor;
         rem_ff <= '0;
         neg_ff <= req.dividend[DVD_W-1] ^ req.divisor[DSR_W-1];
      end else if (run_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[DVD_W-2:0], qbit};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? (~dvd_ff + DVD_W'(1)) : dvd_ff;

endmodule

/* src/nddi_mul.sv */
// ----------------------------------------------------------------------------
// nddi_mul
// Shift-add Q30.16 by Q17.16 multiplier, one multiplier bit per cycle, clipped result.
// ----------------------------------------------------------------------------
module nddi_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  nddi_pkg::mul_req_type req,
   output nddi_pkg::mul_rsp_type rsp
);

   localparam int COEF_W = nddi_pkg::COEF_W;
   localparam int MB_W   = nddi_pkg::MB_W;
   localparam int HW     = COEF_W + 1;
   localparam int PW     = nddi_pkg::PROD_W;
   localparam int CW     = $clog2(MB_W);

   logic              run_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [COEF_W-1:0] ma_ff;
   logic [HW-1:0]     hi_ff;
   logic [MB_W-1:0]   lo_ff;
   logic              neg_ff;

   logic [HW-1:0]     sum;
   logic [PW-1:0]     prod;
   logic              ovf;
   logic [COEF_W-1:0] mag;

   assign sum  = lo_ff[0] ? (hi_ff + {1'b0, ma_ff}) : hi_ff;
   assign prod = {hi_ff, lo_ff};
   assign ovf  = |prod[PW-1:COEF_W+15];
   assign mag  = {1'b0, prod[COEF_W+14:16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(MB_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         ma_ff  <= req.a[COEF_W-1] ? (~req.a + COEF_W'(1)) : req.a;
         lo_ff  <= req.b[MB_W-1] ? (~req.b + MB_W'(1)) : req.b;
         hi_ff  <= '0;
         neg_ff <= req.a[COEF_W-1] ^ req.b[MB_W-1];
      end else if (run_ff) begin
         hi_ff <= {1'b0, sum[HW-1:1]};
         lo_ff <= {sum[0], lo_ff[MB_W-1:1]};
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.sat     = ovf;
   assign rsp.product = ovf ? (neg_ff ? nddi_pkg::C_MIN : nddi_pkg::C_MAX)
                            : (neg_ff ? (~mag + COEF_W'(1)) : mag);

endmodule

/* src/newton_divided_difference_interp.sv */
// ----------------------------------------------------------------------------
// newton_divided_difference_interp
// Newton divided-difference interpolation over equispaced Q16.16 nodes.
// ----------------------------------------------------------------------------
// Issue a request with start while busy is low; every request returns exactly
// one result on rsp_valid, a single-cycle strobe that the receiver must take.
// A load that does not complete a node set and an evaluate before a build
// answer in the cycle after acceptance. The load that completes the set runs
// the build: a step division, placement of the n nodes and n(n-1)/2 divided
// differences on the shared serial divider; a zero step ends it with an error.
// An evaluate runs n-1 multiply-add steps on the serial multiplier.
// ----------------------------------------------------------------------------
module newton_divided_difference_interp (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [31:0] req_sample_value,
   input  logic [31:0] req_eval_point,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int MAX_NODES = nddi_pkg::MAX_NODES;
   localparam int IDX_W     = nddi_pkg::IDX_W;
   localparam int CNT_W     = nddi_pkg::CNT_W;
   localparam int COEF_W    = nddi_pkg::COEF_W;
   localparam int DSR_W     = nddi_pkg::DSR_W;
   localparam int DVD_W     = nddi_pkg::DVD_W;

   typedef enum logic [3:0] {
      S_IDLE, S_STEP, S_FILL, S_B_RD0, S_B_RD1, S_B_RD2, S_B_DIV,
      S_EV_TOP, S_EV_TOP2, S_EV_RD, S_EV_CAP, S_EV_MUL, S_EV_FIN
   } state_type;

   state_type         state_ff;
   logic [31:0]       node_start_ff;
   logic [31:0]       node_end_ff;
   logic [5:0]        node_count_ff;
   logic [CNT_W-1:0]  li_ff;
   logic              built_ff;
   logic [CNT_W-1:0]  nused_ff;
   logic [CNT_W-1:0]  i_ff;
   logic [CNT_W-1:0]  j_ff;
   logic [COEF_W-1:0] cj_ff;
   logic [31:0]       xj_ff;
   logic [COEF_W-1:0] v_ff;
   logic [31:0]       p_ff;
   logic              sat_ff;
   logic [DSR_W-1:0]  step_ff;
   logic [33:0]       nacc_ff;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_value_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_sat_ff;

   logic [COEF_W-1:0] coef_mem [MAX_NODES];
   logic [31:0]       node_mem [MAX_NODES];
   logic [COEF_W-1:0] coef_rd_ff;
   logic [31:0]       node_rd_ff;

   logic              coef_we;
   logic [IDX_W-1:0]  coef_waddr;
   logic [COEF_W-1:0] coef_wdata;
   logic [IDX_W-1:0]  coef_raddr;
   logic              node_we;
   logic [IDX_W-1:0]  node_waddr;
   logic [IDX_W-1:0]  node_raddr;

   nddi_pkg::div_req_type div_req;
   nddi_pkg::div_rsp_type div_rsp;
   nddi_pkg::mul_req_type mul_req;
   nddi_pkg::mul_rsp_type mul_rsp;

   logic              accept;
   logic [CNT_W-1:0]  nc;
   logic [CNT_W-1:0]  n_eff;
   logic [CNT_W-1:0]  li_base;
   logic [CNT_W-1:0]  li_wr;
   logic [CNT_W-1:0]  li_inc;
   logic              fire_build;
   logic [32:0]       span;
   logic [CNT_W-1:0]  j_m1;
   logic [CNT_W-1:0]  j_mi;
   logic [46:0]       cdiff;
   logic [COEF_W-1:0] q_clip;
   logic              q_sat;
   logic [46:0]       hsum;
   logic [COEF_W-1:0] h_clip;
   logic              h_sat;
   logic [31:0]       f_clip;
   logic              f_sat;

   assign accept = start & ~busy;
   assign busy   = (state_ff != S_IDLE);

   assign nc    = CNT_W'(node_count_ff);
   assign n_eff = (nc < CNT_W'(2)) ? CNT_W'(2) :
                  (nc > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : nc;

   assign li_base    = built_ff ? '0 : li_ff;
   assign li_wr      = (li_base >= CNT_W'(MAX_NODES)) ? '0 : li_base;
   assign li_inc     = li_wr + CNT_W'(1);
   assign fire_build = (li_inc >= n_eff);

   assign span = {node_end_ff[31], node_end_ff} - {node_start_ff[31], node_start_ff};
   assign j_m1 = j_ff - CNT_W'(1);
   assign j_mi = j_ff - i_ff;

   assign cdiff  = {cj_ff[COEF_W-1], cj_ff} - {coef_rd_ff[COEF_W-1], coef_rd_ff};
   assign q_sat  = ~((&div_rsp.quotient[DVD_W-1:COEF_W-1]) |
                     ~(|div_rsp.quotient[DVD_W-1:COEF_W-1]));
   assign q_clip = q_sat ? (div_rsp.quotient[DVD_W-1] ? nddi_pkg::C_MIN : nddi_pkg::C_MAX)
                         : div_rsp.quotient[COEF_W-1:0];

   assign hsum   = {mul_rsp.product[COEF_W-1], mul_rsp.product} + {cj_ff[COEF_W-1], cj_ff};
   assign h_sat  = hsum[46] ^ hsum[45];
   assign h_clip = h_sat ? (hsum[46] ? nddi_pkg::C_MIN : nddi_pkg::C_MAX) : hsum[COEF_W-1:0];

   assign f_sat  = ~((&v_ff[COEF_W-1:31]) | ~(|v_ff[COEF_W-1:31]));
   assign f_clip = f_sat ? (v_ff[COEF_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v_ff[31:0];

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {{(DVD_W-33){span[32]}}, span};
      div_req.divisor  = DSR_W'(n_eff - CNT_W'(1));
      mul_req.start    = (state_ff == S_EV_CAP);
      mul_req.a        = v_ff;
      mul_req.b        = {p_ff[31], p_ff} - {node_rd_ff[31], node_rd_ff};
      if (state_ff == S_B_RD2) begin
         div_req.start    = 1'b1;
         div_req.dividend = {cdiff[46], cdiff, 16'h0000};
         div_req.divisor  = {xj_ff[31], xj_ff} - {node_rd_ff[31], node_rd_ff};
      end else if (accept && req_cmd == nddi_pkg::CMD_LOAD && fire_build) begin
         div_req.start = 1'b1;
      end
   end

   always_comb begin
      coef_we    = 1'b0;
      coef_waddr = li_wr[IDX_W-1:0];
      coef_wdata = {{(COEF_W-32){req_sample_value[31]}}, req_sample_value};
      coef_raddr = j_ff[IDX_W-1:0];
      node_we    = (state_ff == S_FILL);
      node_waddr = j_ff[IDX_W-1:0];
      node_raddr = j_ff[IDX_W-1:0];
      if (state_ff == S_IDLE) begin
         coef_we = accept && (req_cmd == nddi_pkg::CMD_LOAD);
      end else if (state_ff == S_B_DIV) begin
         coef_we    = div_rsp.done;
         coef_waddr = j_ff[IDX_W-1:0];
         coef_wdata = q_clip;
      end
      if (state_ff == S_B_RD1) begin
         coef_raddr = j_m1[IDX_W-1:0];
         node_raddr = j_mi[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= nacc_ff[31:0];
      end
      node_rd_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_start_ff <= 32'h0000_0000;
         node_end_ff   <= 32'h0001_0000;
         node_count_ff <= 6'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            nddi_pkg::CSR_NODE_START: node_start_ff <= csr_wdata;
            nddi_pkg::CSR_NODE_END:   node_end_ff   <= csr_wdata;
            nddi_pkg::CSR_NODE_COUNT: node_count_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         li_ff        <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  sat_ff <= 1'b0;
                  if (req_cmd == nddi_pkg::CMD_LOAD) begin
                     built_ff <= 1'b0;
                     if (fire_build) begin
                        li_ff    <= '0;
                        nused_ff <= n_eff;
                        state_ff <= S_STEP;
                     end else begin
                        li_ff         <= li_inc;
                        rsp_valid_ff  <= 1'b1;
                        rsp_value_ff  <= '0;
                        rsp_status_ff <= nddi_pkg::ST_STORED;
                        rsp_sat_ff    <= 1'b0;
                     end
                  end else if (!built_ff) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_value_ff  <= '0;
                     rsp_status_ff <= nddi_pkg::ST_ERROR;
                     rsp_sat_ff    <= 1'b0;
                  end else begin
                     p_ff     <= req_eval_point;
                     j_ff     <= nused_ff - CNT_W'(1);
                     state_ff <= S_EV_TOP;
                  end
               end
            end
            S_STEP: begin
               if (div_rsp.done) begin
                  step_ff <= div_rsp.quotient[DSR_W-1:0];
                  nacc_ff <= {{2{node_start_ff[31]}}, node_start_ff};
                  j_ff    <= '0;
                  if (div_rsp.quotient[DSR_W-1:0] == '0) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_value_ff  <= '0;
                     rsp_status_ff <= nddi_pkg::ST_ERROR;
                     rsp_sat_ff    <= 1'b0;
                     state_ff      <= S_IDLE;
                  end else begin
                     state_ff <= S_FILL;
                  end
               end
            end
            S_FILL: begin
               nacc_ff <= nacc_ff + {step_ff[DSR_W-1], step_ff};
               if (j_ff == nused_ff - CNT_W'(1)) begin
                  i_ff     <= CNT_W'(1);
                  state_ff <= S_B_RD0;
               end else begin
                  j_ff <= j_ff + CNT_W'(1);
               end
            end
            S_B_RD0: state_ff <= S_B_RD1;
            S_B_RD1: begin
               cj_ff    <= coef_rd_ff;
               xj_ff    <= node_rd_ff;
               state_ff <= S_B_RD2;
            end
            S_B_RD2: state_ff <= S_B_DIV;
            S_B_DIV: begin
               if (div_rsp.done) begin
                  sat_ff <= sat_ff | q_sat;
                  if (j_ff == i_ff) begin
                     if (i_ff == nused_ff - CNT_W'(1)) begin
                        built_ff      <= 1'b1;
                        rsp_valid_ff  <= 1'b1;
                        rsp_value_ff  <= '0;
                        rsp_status_ff <= nddi_pkg::ST_BUILT;
                        rsp_sat_ff    <= sat_ff | q_sat;
                        state_ff      <= S_IDLE;
                     end else begin
                        i_ff     <= i_ff + CNT_W'(1);
                        j_ff     <= nused_ff - CNT_W'(1);
                        state_ff <= S_B_RD0;
                     end
                  end else begin
                     j_ff     <= j_m1;
                     state_ff <= S_B_RD0;
                  end
               end
            end
            S_EV_TOP: state_ff <= S_EV_TOP2;
            S_EV_TOP2: begin
               v_ff     <= coef_rd_ff;
               j_ff     <= j_m1;
               state_ff <= S_EV_RD;
            end
            S_EV_RD: state_ff <= S_EV_CAP;
            S_EV_CAP: begin
               cj_ff    <= coef_rd_ff;
               state_ff <= S_EV_MUL;
            end
            S_EV_MUL: begin
               if (mul_rsp.done) begin
                  v_ff   <= h_clip;
                  sat_ff <= sat_ff | mul_rsp.sat | h_sat;
                  if (j_ff == '0) begin
                     state_ff <= S_EV_FIN;
                  end else begin
                     j_ff     <= j_m1;
                     state_ff <= S_EV_RD;
                  end
               end
            end
            S_EV_FIN: begin
               rsp_valid_ff  <= 1'b1;
               rsp_value_ff  <= f_clip;
               rsp_status_ff <= nddi_pkg::ST_VALUE;
               rsp_sat_ff    <= sat_ff | f_sat;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   nddi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   nddi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule
